[src/fbpa_pkg.sv]
// Shared types, codes and constants of the fixed block pool allocator.
package fbpa_pkg;

	localparam int unsigned MAX_BLOCKS_DEF = 256;

	localparam int unsigned OPCODE_W = 2;
	localparam int unsigned INDEX_W = 8;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned COUNT_W = 9;
	localparam int unsigned BYTES_W = 16;
	localparam int unsigned ADDR_W = 32;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [OPCODE_W-1:0] OP_INIT = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_ALLOC = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_FREE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOINIT = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd2;

	localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 9'd256;
	localparam logic [BYTES_W-1:0] BLOCK_BYTES_RST = 16'd64;
	localparam logic [ADDR_W-1:0] BASE_ADDRESS_RST = 32'd0;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [INDEX_W-1:0] block_index;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [INDEX_W-1:0] granted_index;
		logic [ADDR_W-1:0] granted_address;
		logic [COUNT_W-1:0] free_count;
	} out_item_t;

	typedef struct packed {
		logic latch;
		logic init_start;
		logic init_step;
		logic init_finish;
		logic alloc_read;
		logic alloc_pop;
		logic free_push;
		logic res_load;
		logic [STATUS_W-1:0] res_status;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic [OPCODE_W-1:0] op;
		logic ready_flag;
		logic head_null;
		logic idx_bad;
		logic cfg_bad;
		logic walk_last;
	} sts_t;

endpackage

[src/fbpa_ctrl.sv]
// Controller state machine of the fixed block pool allocator.
module fbpa_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input fbpa_pkg::sts_t sts,
	output fbpa_pkg::cmd_t cmd
);
	import fbpa_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_WALK = 3'd2;
	localparam logic [2:0] S_ALLOC = 3'd3;
	localparam logic [2:0] S_FINISH = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic out_valid_q;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_FINISH;
				case (sts.op)
					OP_INIT: begin
						if (sts.cfg_bad) begin
							cmd.res_load = 1'b1;
							cmd.res_status = ST_RANGE;
						end else begin
							cmd.init_start = 1'b1;
							state_d = S_WALK;
						end
					end
					OP_ALLOC: begin
						if (!sts.ready_flag) begin
							cmd.res_load = 1'b1;
							cmd.res_status = ST_NOINIT;
						end else if (sts.head_null) begin
							cmd.res_load = 1'b1;
							cmd.res_status = ST_EMPTY;
						end else begin
							cmd.alloc_read = 1'b1;
							state_d = S_ALLOC;
						end
					end
					OP_FREE: begin
						cmd.res_load = 1'b1;
						if (!sts.ready_flag) begin
							cmd.res_status = ST_NOINIT;
						end else if (sts.idx_bad) begin
							cmd.res_status = ST_RANGE;
						end else begin
							cmd.free_push = 1'b1;
							cmd.res_status = ST_OK;
						end
					end
					default: begin
						cmd.res_load = 1'b1;
						cmd.res_status = ST_RANGE;
					end
				endcase
			end
			S_WALK: begin
				cmd.init_step = 1'b1;
				if (sts.walk_last) begin
					cmd.init_finish = 1'b1;
					cmd.res_load = 1'b1;
					cmd.res_status = ST_OK;
					state_d = S_FINISH;
				end
			end
			S_ALLOC: begin
				cmd.alloc_pop = 1'b1;
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[src/fbpa_dpath.sv]
// Datapath of the fixed block pool allocator: link store, list state and result registers.
module fbpa_dpath #(
	parameter int unsigned MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
	input logic clk,
	input logic arst_n,
	input fbpa_pkg::in_item_t in_data,
	input logic cfg_valid,
	input logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_data,
	input fbpa_pkg::cmd_t cmd,
	output fbpa_pkg::sts_t sts,
	output fbpa_pkg::out_item_t out_data
);
	import fbpa_pkg::*;

	localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
	localparam int unsigned PTR_W = $clog2(MAX_BLOCKS + 1);
	localparam int unsigned CMP_W = (PTR_W > COUNT_W) ? PTR_W : COUNT_W;
	localparam int unsigned PROD_W = IDX_W + BYTES_W;
	localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(MAX_BLOCKS);
	localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_BLOCKS);

	logic [COUNT_W-1:0] block_count_q;
	logic [BYTES_W-1:0] block_bytes_q;
	logic [ADDR_W-1:0] base_address_q;

	logic [PTR_W-1:0] link_mem_q [MAX_BLOCKS];
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] free_total_q;
	logic ready_flag_q;

	logic [OPCODE_W-1:0] op_q;
	logic [INDEX_W-1:0] idx_q;
	logic [IDX_W-1:0] walk_q;
	logic [PTR_W-1:0] n_q;
	logic [PTR_W-1:0] rdata_q;
	logic [PROD_W-1:0] product_s1;
	logic [STATUS_W-1:0] res_status_q;
	logic [INDEX_W-1:0] res_index_q;
	logic [ADDR_W-1:0] res_address_q;

	logic [CMP_W-1:0] idx_ext;
	logic [CMP_W-1:0] count_ext;
	logic [PTR_W-1:0] n_sat;
	logic [PTR_W-1:0] walk_next;
	logic walk_last;
	logic [IDX_W-1:0] idx_addr;
	logic [IDX_W-1:0] head_addr;

	assign idx_ext = CMP_W'(idx_q);
	assign count_ext = CMP_W'(block_count_q);
	assign n_sat = (count_ext > MAX_CMP) ? NULL_PTR : PTR_W'(count_ext);
	assign walk_next = PTR_W'(walk_q) + PTR_W'(1);
	assign walk_last = (walk_next == n_q);
	assign idx_addr = IDX_W'(idx_ext);
	assign head_addr = head_q[IDX_W-1:0];

	always_comb begin
		sts.op = op_q;
		sts.ready_flag = ready_flag_q;
		sts.head_null = (head_q == NULL_PTR);
		sts.idx_bad = (idx_ext >= count_ext) || (idx_ext >= MAX_CMP);
		sts.cfg_bad = (block_count_q == '0) || (block_bytes_q == '0);
		sts.walk_last = walk_last;
	end

	always_ff @(posedge clk) begin
		if (cmd.init_step) begin
			link_mem_q[walk_q] <= walk_last ? NULL_PTR : walk_next;
		end else if (cmd.free_push) begin
			link_mem_q[idx_addr] <= head_q;
		end
		if (cmd.alloc_read) begin
			rdata_q <= link_mem_q[head_addr];
			product_s1 <= PROD_W'(head_addr) * PROD_W'(block_bytes_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q <= in_data.opcode;
			idx_q <= in_data.block_index;
		end
		if (cmd.init_start) begin
			walk_q <= '0;
			n_q <= n_sat;
		end else if (cmd.init_step) begin
			walk_q <= walk_q + IDX_W'(1);
		end
		if (cmd.alloc_pop) begin
			res_status_q <= ST_OK;
			res_index_q <= INDEX_W'(head_q);
			res_address_q <= base_address_q + ADDR_W'(product_s1);
		end else if (cmd.res_load) begin
			res_status_q <= cmd.res_status;
			res_index_q <= '0;
			res_address_q <= '0;
		end
		if (cmd.load_out) begin
			out_data.status <= res_status_q;
			out_data.granted_index <= res_index_q;
			out_data.granted_address <= res_address_q;
			out_data.free_count <= COUNT_W'(free_total_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= BLOCK_COUNT_RST;
			block_bytes_q <= BLOCK_BYTES_RST;
			base_address_q <= BASE_ADDRESS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BLOCK_COUNT: block_count_q <= cfg_data[COUNT_W-1:0];
				REG_BLOCK_BYTES: block_bytes_q <= cfg_data[BYTES_W-1:0];
				REG_BASE_ADDRESS: base_address_q <= cfg_data[ADDR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= NULL_PTR;
			free_total_q <= '0;
			ready_flag_q <= 1'b0;
		end else if (cmd.init_finish) begin
			head_q <= '0;
			free_total_q <= n_q;
			ready_flag_q <= 1'b1;
		end else if (cmd.alloc_pop) begin
			head_q <= rdata_q;
			if (free_total_q != '0) begin
				free_total_q <= free_total_q - PTR_W'(1);
			end
		end else if (cmd.free_push) begin
			head_q <= PTR_W'(idx_ext);
			if (free_total_q != NULL_PTR) begin
				free_total_q <= free_total_q + PTR_W'(1);
			end
		end
	end

endmodule

[src/fixed_block_pool_allocator_core.sv]
// Top level of the fixed block pool allocator.
// The pool is a singly linked free list kept in a link store of MAX_BLOCKS entries. An init
// transfer links blocks 0 to block_count-1 in order, one link store write per cycle, with
// block_count limited to MAX_BLOCKS. An alloc transfer reads the link store at the head, then
// updates the head and forms base_address + index * block_bytes from a registered product.
// Free and error cases go from the decode state straight to the finish state. One item is
// worked on at a time, and a new input transfer is taken the cycle after the previous result
// enters the output register, even while that result still waits to be taken. The link store
// needs no clearing after reset; alloc and free before the first init report not initialized.
// Configuration writes are always taken and should only be made while the block is idle.
module fixed_block_pool_allocator_core #(
	parameter int unsigned MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input fbpa_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output fbpa_pkg::out_item_t out_data
);
	import fbpa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	fbpa_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts(sts),
		.cmd(cmd)
	);

	fbpa_dpath #(
		.MAX_BLOCKS(MAX_BLOCKS)
	) u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.in_data(in_data),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd(cmd),
		.sts(sts),
		.out_data(out_data)
	);

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// Testbench for the fixed block pool allocator core against a free-list predictor.
module tb_top;
	import fbpa_pkg::*;

	localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam logic [COUNT_W-1:0] HEAD_NULL = 9'd256;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned DRAIN_CYCLES = 16;
	localparam int unsigned SEGMENT_ITEMS = 90;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;

	int unsigned send_idle_pct = 31;
	int unsigned recv_idle_pct = 66;
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	out_item_t pending_results [$];

	logic [COUNT_W-1:0] link_mem [MAX_BLOCKS_DEF];
	logic [COUNT_W-1:0] head_blk = HEAD_NULL;
	logic [COUNT_W-1:0] spare_total = '0;
	logic pool_ready = 1'b0;
	logic [COUNT_W-1:0] cnt_reg = BLOCK_COUNT_RST;
	logic [BYTES_W-1:0] bytes_reg = BLOCK_BYTES_RST;
	logic [ADDR_W-1:0] base_reg = BASE_ADDRESS_RST;

	fixed_block_pool_allocator_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic out_item_t pool_step(input in_item_t item);
		out_item_t r;
		logic [COUNT_W-1:0] n;
		logic [COUNT_W-1:0] blk;
		int i;
		r = '0;
		case (item.opcode)
			OP_INIT: begin
				if (cnt_reg == 0 || bytes_reg == 0) begin
					r.status = ST_RANGE;
				end else begin
					n = (cnt_reg > MAX_BLOCKS_DEF) ? COUNT_W'(MAX_BLOCKS_DEF) : cnt_reg;
					for (i = 0; i < n; i++) begin
						link_mem[i] = (i + 1 == n) ? HEAD_NULL : COUNT_W'(i + 1);
					end
					head_blk = '0;
					spare_total = n;
					pool_ready = 1'b1;
					r.status = ST_OK;
				end
			end
			OP_ALLOC: begin
				if (!pool_ready) begin
					r.status = ST_NOINIT;
				end else if (head_blk >= HEAD_NULL) begin
					r.status = ST_EMPTY;
				end else begin
					blk = head_blk;
					head_blk = link_mem[blk[INDEX_W-1:0]];
					if (spare_total > 0) spare_total = spare_total - COUNT_W'(1);
					r.status = ST_OK;
					r.granted_index = blk[INDEX_W-1:0];
					r.granted_address = base_reg + ADDR_W'(blk) * ADDR_W'(bytes_reg);
				end
			end
			OP_FREE: begin
				if (!pool_ready) begin
					r.status = ST_NOINIT;
				end else if (COUNT_W'(item.block_index) >= cnt_reg) begin
					r.status = ST_RANGE;
				end else begin
					link_mem[item.block_index] = head_blk;
					head_blk = COUNT_W'(item.block_index);
					if (spare_total < MAX_BLOCKS_DEF) spare_total = spare_total + COUNT_W'(1);
					r.status = ST_OK;
				end
			end
			default: begin
				r.status = ST_RANGE;
			end
		endcase
		r.free_count = spare_total;
		return r;
	endfunction

	task automatic send_item(input logic [OPCODE_W-1:0] opcode, input logic [INDEX_W-1:0] idx,
			output out_item_t predicted);
		in_item_t item;
		item.opcode = opcode;
		item.block_index = idx;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (!in_ready);
		predicted = pool_step(item);
		pending_results.push_back(predicted);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data,
			input logic last);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_BLOCK_COUNT: cnt_reg = data[COUNT_W-1:0];
			REG_BLOCK_BYTES: bytes_reg = data[BYTES_W-1:0];
			REG_BASE_ADDRESS: base_reg = data[ADDR_W-1:0];
			default: ;
		endcase
		if (last) cfg_valid <= 1'b0;
	endtask

	task automatic set_pool(input logic [COUNT_W-1:0] cnt, input logic [BYTES_W-1:0] bytes,
			input logic [ADDR_W-1:0] base);
		logic [CFG_DATA_W-1:0] junk;
		junk = $urandom();
		write_reg(REG_BLOCK_COUNT, {junk[CFG_DATA_W-1:COUNT_W], cnt}, 1'b0);
		junk = $urandom();
		write_reg(REG_BLOCK_BYTES, {junk[CFG_DATA_W-1:BYTES_W], bytes}, 1'b0);
		write_reg(REG_BASE_ADDRESS, base, 1'b1);
	endtask

	task automatic check_field(input string label, input logic [ADDR_W-1:0] want,
			input logic [ADDR_W-1:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %0h actual %0h", $time, label, want, got);
			error_count++;
		end
	endtask

	task automatic test_uninitialized();
		out_item_t res;
		send_item(OP_ALLOC, 8'h00, res);
		send_item(OP_FREE, 8'hFF, res);
		send_item(OP_UNUSED, 8'h5A, res);
	endtask

	task automatic test_bad_config();
		out_item_t res;
		wait_idle();
		write_reg(REG_SPARE, CFG_DATA_W'($urandom()), 1'b0);
		set_pool(9'd0, 16'd64, 32'h0000_0000);
		send_item(OP_INIT, 8'h00, res);
		send_item(OP_ALLOC, 8'h00, res);
		wait_idle();
		set_pool(9'd4, 16'd0, 32'h1234_5678);
		send_item(OP_INIT, 8'h00, res);
	endtask

	task automatic test_wrap_and_double_free();
		out_item_t res;
		wait_idle();
		set_pool(9'd3, 16'hFFFF, 32'hFFFF_FFF0);
		send_item(OP_INIT, 8'hFF, res);
		repeat (4) send_item(OP_ALLOC, 8'h00, res);
		send_item(OP_FREE, 8'd3, res);
		send_item(OP_FREE, 8'd2, res);
		send_item(OP_FREE, 8'd2, res);
		send_item(OP_ALLOC, 8'h00, res);
		send_item(OP_ALLOC, 8'h00, res);
	endtask

	task automatic test_count_floor();
		out_item_t res;
		wait_idle();
		set_pool(9'd1, 16'd1, 32'h0000_0000);
		send_item(OP_INIT, 8'h00, res);
		send_item(OP_ALLOC, 8'h00, res);
		send_item(OP_FREE, 8'd0, res);
		send_item(OP_FREE, 8'd0, res);
		repeat (3) send_item(OP_ALLOC, 8'h00, res);
	endtask

	task automatic test_count_saturation();
		out_item_t res;
		wait_idle();
		set_pool(9'd511, 16'h8000, 32'h8000_0000);
		send_item(OP_INIT, 8'h00, res);
		send_item(OP_FREE, 8'hFF, res);
		send_item(OP_ALLOC, 8'h00, res);
	endtask

	task automatic test_random_traffic();
		logic [INDEX_W-1:0] held [$];
		out_item_t res;
		int unsigned pick;
		int unsigned k;
		logic [COUNT_W-1:0] cnt;
		logic [BYTES_W-1:0] bytes;
		logic [ADDR_W-1:0] base;
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 31;
					recv_idle_pct = 66;
				end
				1: begin
					send_idle_pct = 66;
					recv_idle_pct = 31;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int seg = 0; seg < 3; seg++) begin
				wait_idle();
				pick = $urandom_range(99);
				if (pick < 60) cnt = COUNT_W'($urandom_range(8, 1));
				else if (pick < 75) cnt = COUNT_W'($urandom_range(255, 9));
				else if (pick < 85) cnt = 9'd256;
				else if (pick < 90) cnt = 9'd1;
				else if (pick < 95) cnt = COUNT_W'($urandom_range(511, 257));
				else cnt = 9'd0;
				pick = $urandom_range(99);
				if (pick < 10) bytes = 16'hFFFF;
				else if (pick < 15) bytes = 16'd1;
				else if (pick < 18) bytes = 16'd0;
				else bytes = BYTES_W'($urandom_range(65535, 1));
				pick = $urandom_range(99);
				if (pick < 10) base = 32'hFFFF_FFFF;
				else if (pick < 15) base = 32'h0000_0000;
				else base = $urandom();
				set_pool(cnt, bytes, base);
				if ($urandom_range(99) < 85) begin
					send_item(OP_INIT, INDEX_W'($urandom()), res);
					if (res.status == ST_OK) held.delete();
				end
				for (int n = 0; n < SEGMENT_ITEMS; n++) begin
					pick = $urandom_range(99);
					if (pick < 45 || (pick < 85 && held.size() == 0)) begin
						send_item(OP_ALLOC, INDEX_W'($urandom()), res);
						if (res.status == ST_OK) held.push_back(res.granted_index);
					end else if (pick < 85) begin
						k = $urandom_range(held.size() - 1);
						send_item(OP_FREE, held[k], res);
						held.delete(k);
					end else if (pick < 92) begin
						send_item(OP_FREE, INDEX_W'($urandom()), res);
					end else if (pick < 95) begin
						send_item(OP_UNUSED, INDEX_W'($urandom()), res);
					end else begin
						send_item(OP_INIT, INDEX_W'($urandom()), res);
						if (res.status == ST_OK) held.delete();
					end
				end
			end
		end
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t ns: unexpected result, expected none actual %h", $time, out_data);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", ADDR_W'(want.status), ADDR_W'(out_data.status));
				check_field("granted_index", ADDR_W'(want.granted_index),
					ADDR_W'(out_data.granted_index));
				check_field("granted_address", want.granted_address, out_data.granted_address);
				check_field("free_count", ADDR_W'(want.free_count), ADDR_W'(out_data.free_count));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_uninitialized();
		test_bad_config();
		test_wrap_and_double_free();
		test_count_floor();
		test_count_saturation();
		test_random_traffic();
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

[filelist.f]
src/fbpa_pkg.sv
src/fbpa_ctrl.sv
src/fbpa_dpath.sv
src/fixed_block_pool_allocator_core.sv
test/tb_top.sv
